@@ src/drt_pkg.sv @@
package drt_pkg;

  // largest frame the store holds
  localparam int unsigned MaxWidth  = 512;
  localparam int unsigned MaxHeight = 512;

  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned RowW  = $clog2(MaxHeight);
  localparam int unsigned AddrW = RowW + ColW;

  // fixed field widths
  localparam int unsigned PixelW = 16;
  localparam int unsigned CfgW   = 10;
  localparam int unsigned BoxW   = 9;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned OutW   = 1 + 4 * BoxW;
  localparam int unsigned OutBytesW = ((OutW + 7) / 8) * 8;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  // register indexes
  localparam logic [IdxW-1:0] RegFrameWidth  = IdxW'(0);
  localparam logic [IdxW-1:0] RegFrameHeight = IdxW'(1);

  localparam logic [CfgW-1:0] ResetWidth  = CfgW'(480);
  localparam logic [CfgW-1:0] ResetHeight = CfgW'(320);

  // last column and row in use, already clamped
  typedef struct packed {
    logic [ColW-1:0] last_col;
    logic [RowW-1:0] last_row;
  } size_cfg_t;

  // one classified pixel on its way to the back end
  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic [ColW-1:0]   col;
    logic [RowW-1:0]   row;
    logic              frame_end;
  } entry_t;

  // register value to last index in use: zero acts as one, large values clamp
  function automatic logic [ColW-1:0] last_col_of(logic [CfgW-1:0] v);
    logic [CfgW+ColW:0] ext;
    ext = (CfgW + ColW + 1)'(v);
    if (v == '0) begin
      return '0;
    end else if (ext > (CfgW + ColW + 1)'(MaxWidth)) begin
      return ColW'(MaxWidth - 1);
    end else begin
      return ColW'(ext - 1'b1);
    end
  endfunction

  function automatic logic [RowW-1:0] last_row_of(logic [CfgW-1:0] v);
    logic [CfgW+RowW:0] ext;
    ext = (CfgW + RowW + 1)'(v);
    if (v == '0) begin
      return '0;
    end else if (ext > (CfgW + RowW + 1)'(MaxHeight)) begin
      return RowW'(MaxHeight - 1);
    end else begin
      return RowW'(ext - 1'b1);
    end
  endfunction

endpackage

@@ src/drt_front.sv @@
module drt_front import drt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  size_cfg_t         size_i,
  input  logic              clearing_i,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [PixelW-1:0] pixel_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output entry_t            q_entry_o
);

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            row_end, frame_end;

  assign s_ready_o = !q_full_i && !clearing_i;
  assign q_push_o  = s_valid_i && s_ready_o;

  assign row_end   = (col_q >= size_i.last_col);
  assign frame_end = row_end && (row_q >= size_i.last_row);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (q_push_o) begin
      if (!row_end) begin
        col_d = col_q + 1'b1;
      end else begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + 1'b1;
      end
    end
  end

  always_comb begin
    q_entry_o.pixel     = pixel_i;
    q_entry_o.col       = col_q;
    q_entry_o.row       = row_q;
    q_entry_o.frame_end = frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

@@ src/drt_fifo.sv @@
module drt_fifo import drt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t data_o
);

  entry_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]   wptr_q, rptr_q;
  logic [QPtrW:0]     count_q, count_d;

  assign full_o  = (count_q == (QPtrW + 1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

@@ src/drt_back.sv @@
module drt_back import drt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  output logic                 clearing_o,
  input  logic                 q_empty_i,
  input  entry_t               q_entry_i,
  output logic                 q_pop_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [OutBytesW-1:0] m_data_o
);

  // frame store
  logic [PixelW-1:0] store_q [2**AddrW];

  logic             clear_q;
  logic [AddrW-1:0] clr_addr_q;

  // read stage
  logic              a_valid_q;
  entry_t            a_entry_q;
  logic [PixelW-1:0] rdata_q;
  logic              a_fire, a_load;
  logic [AddrW-1:0]  a_addr, q_addr;

  // last write, forwarded over the stale read
  logic              lw_valid_q;
  logic [AddrW-1:0]  lw_addr_q;
  logic [PixelW-1:0] lw_pixel_q;
  logic [PixelW-1:0] prev_pixel;
  logic              changed;

  // box
  logic            any_q, any_d;
  logic [ColW:0]   min_col_q, min_col_d;
  logic [RowW:0]   min_row_q, min_row_d;
  logic [ColW-1:0] max_col_q, max_col_d;
  logic [RowW-1:0] max_row_q, max_row_d;

  // result register
  logic            m_valid_q;
  logic            r_changed_q;
  logic [BoxW-1:0] r_left_q, r_top_q, r_right_q, r_bottom_q;

  assign clearing_o = clear_q;
  assign q_addr = {q_entry_i.row, q_entry_i.col};
  assign a_addr = {a_entry_q.row, a_entry_q.col};

  assign a_fire  = a_valid_q && (!a_entry_q.frame_end || !m_valid_q || m_ready_i);
  assign a_load  = !q_empty_i && !clear_q && (!a_valid_q || a_fire);
  assign q_pop_o = a_load;

  assign prev_pixel = (lw_valid_q && (lw_addr_q == a_addr)) ? lw_pixel_q : rdata_q;
  assign changed    = (prev_pixel != a_entry_q.pixel);

  always_comb begin
    any_d     = any_q;
    min_col_d = min_col_q;
    min_row_d = min_row_q;
    max_col_d = max_col_q;
    max_row_d = max_row_q;
    if (changed) begin
      any_d = 1'b1;
      if ((ColW + 1)'(a_entry_q.col) < min_col_q) min_col_d = (ColW + 1)'(a_entry_q.col);
      if ((RowW + 1)'(a_entry_q.row) < min_row_q) min_row_d = (RowW + 1)'(a_entry_q.row);
      if (a_entry_q.col > max_col_q) max_col_d = a_entry_q.col;
      if (a_entry_q.row > max_row_q) max_row_d = a_entry_q.row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear_q) begin
      store_q[clr_addr_q] <= '0;
    end else if (a_fire) begin
      store_q[a_addr] <= a_entry_q.pixel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      rdata_q   <= store_q[q_addr];
      a_entry_q <= q_entry_i;
    end
    if (a_fire) begin
      lw_addr_q  <= a_addr;
      lw_pixel_q <= a_entry_q.pixel;
    end
    if (a_fire && a_entry_q.frame_end) begin
      r_changed_q <= any_d;
      r_left_q    <= any_d ? BoxW'(min_col_d) : '0;
      r_top_q     <= any_d ? BoxW'(min_row_d) : '0;
      r_right_q   <= any_d ? BoxW'(max_col_d) : '0;
      r_bottom_q  <= any_d ? BoxW'(max_row_d) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q    <= 1'b1;
      clr_addr_q <= '0;
      a_valid_q  <= 1'b0;
      lw_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      any_q      <= 1'b0;
      min_col_q  <= (ColW + 1)'(MaxWidth);
      min_row_q  <= (RowW + 1)'(MaxHeight);
      max_col_q  <= '0;
      max_row_q  <= '0;
    end else begin
      if (clear_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == '1) clear_q <= 1'b0;
      end
      if (a_load) begin
        a_valid_q <= 1'b1;
      end else if (a_fire) begin
        a_valid_q <= 1'b0;
      end
      if (a_fire) begin
        lw_valid_q <= 1'b1;
        if (a_entry_q.frame_end) begin
          any_q     <= 1'b0;
          min_col_q <= (ColW + 1)'(MaxWidth);
          min_row_q <= (RowW + 1)'(MaxHeight);
          max_col_q <= '0;
          max_row_q <= '0;
        end else begin
          any_q     <= any_d;
          min_col_q <= min_col_d;
          min_row_q <= min_row_d;
          max_col_q <= max_col_d;
          max_row_q <= max_row_d;
        end
      end
      if (a_fire && a_entry_q.frame_end) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = OutBytesW'({r_bottom_q, r_right_q, r_top_q, r_left_q, r_changed_q});

endmodule

@@ src/dirty_rectangle_tracker.sv @@
// dirty rectangle tracker: takes one 16-bit pixel per beat in row-major order, compares it
// with the same position of the previous frame held in an on-chip frame store, writes the
// new pixel back and grows a bounding box over the changed pixels. at the last pixel of each
// frame one result beat carries the changed flag and the box (all zero when nothing changed).
// frame size comes from two registers (zero acts as one, values past the store clamp).
// sustained rate is one pixel per clock: the front end counts columns and rows, a small queue
// decouples it from the back end, whose single store read port and one compare stage take one
// pixel each cycle. the frame's last pixel goes through the queue and the compare stage into
// the result register; a result still waiting holds the next frame end pixel in the compare
// stage, and the queue then fills and drops s_axis_tready_o.
// after reset the store is cleared one entry per cycle, all 262144 entries, with s_axis_tready_o
// low for that whole time; configuration writes are taken at any time.
module dirty_rectangle_tracker import drt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // pixel stream in
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [PixelW-1:0]    s_axis_tdata_i,   // [15:0] pixel
  // box result out
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutBytesW-1:0] m_axis_tdata_o,   // box_changed, box_left, box_top,
                                                 // box_right, box_bottom, zero pad
  // register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [IdxW-1:0]      cfg_index_i,
  input  logic [CfgW-1:0]      cfg_data_i
);

  logic [CfgW-1:0] width_q, height_q;
  size_cfg_t       size;

  logic   clearing;
  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_in, q_out;

  // registers are always writable, unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegFrameWidth:  width_q  <= cfg_data_i;
        RegFrameHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped last column and row, used by the counters
  always_comb begin
    size.last_col = last_col_of(width_q);
    size.last_row = last_row_of(height_q);
  end

  // front end: counts position and flags the frame end
  drt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size),
    .clearing_i (clearing),
    .s_valid_i  (s_axis_tvalid_i),
    .s_ready_o  (s_axis_tready_o),
    .pixel_i    (s_axis_tdata_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_in)
  );

  // short queue so the back end can stall on the result without stopping intake at once
  drt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  // back end: store read, compare, write back, box update and result register
  drt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clearing_o (clearing),
    .q_empty_i  (q_empty),
    .q_entry_i  (q_out),
    .q_pop_o    (q_pop),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_data_o   (m_axis_tdata_o)
  );

endmodule

@@ tb/sv/dirty_box_checker.sv @@
`timescale 1ns / 100ps
module dirty_box_checker import drt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pix_valid_i,
  input  logic                 pix_ready_i,
  input  logic [PixelW-1:0]    pix_data_i,
  input  logic                 box_valid_i,
  input  logic                 box_ready_i,
  input  logic [OutBytesW-1:0] box_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [IdxW-1:0]      cfg_index_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  // result beat layout, lowest bit first: changed, left, top, right, bottom
  typedef struct packed {
    logic [BoxW-1:0] bottom;
    logic [BoxW-1:0] right;
    logic [BoxW-1:0] top;
    logic [BoxW-1:0] left;
    logic            changed;
  } box_t;

  logic [PixelW-1:0] shadow_frame [MaxWidth*MaxHeight];
  logic [CfgW-1:0]   width_reg, height_reg;
  logic [ColW-1:0]   col_pos;
  logic [RowW-1:0]   row_pos;
  int unsigned       left_min, top_min, right_max, bottom_max;
  logic              dirty;
  box_t              pending_boxes [$];
  int                fail_count;

  initial begin
    foreach (shadow_frame[i]) shadow_frame[i] = '0;
  end

  function automatic int unsigned used_size(input logic [CfgW-1:0] v, input int unsigned cap);
    if (v == '0) return 1;
    if (32'(v) > cap) return cap;
    return 32'(v);
  endfunction

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    int unsigned w, h, addr;
    logic        row_done, frame_done;
    box_t        want, got;
    if (!rst_ni) begin
      width_reg  = ResetWidth;
      height_reg = ResetHeight;
      col_pos    = '0;
      row_pos    = '0;
      left_min   = MaxWidth;
      top_min    = MaxHeight;
      right_max  = 0;
      bottom_max = 0;
      dirty      = 1'b0;
      fail_count = 0;
      pending_boxes.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegFrameWidth: begin
            width_reg = cfg_data_i;
          end
          RegFrameHeight: begin
            height_reg = cfg_data_i;
          end
          default: begin
          end
        endcase
      end

      if (pix_valid_i && pix_ready_i) begin
        w    = used_size(width_reg, MaxWidth);
        h    = used_size(height_reg, MaxHeight);
        addr = int'(row_pos) * MaxWidth + int'(col_pos);
        if (shadow_frame[AddrW'(addr)] != pix_data_i) begin
          dirty = 1'b1;
          if (32'(col_pos) < left_min) left_min = 32'(col_pos);
          if (32'(row_pos) < top_min) top_min = 32'(row_pos);
          if (32'(col_pos) > right_max) right_max = 32'(col_pos);
          if (32'(row_pos) > bottom_max) bottom_max = 32'(row_pos);
        end
        shadow_frame[AddrW'(addr)] = pix_data_i;
        row_done   = (32'(col_pos) >= w - 1);
        frame_done = row_done && (32'(row_pos) >= h - 1);
        if (!row_done) begin
          col_pos = col_pos + 1'b1;
        end else begin
          col_pos = '0;
          if (!frame_done) begin
            row_pos = row_pos + 1'b1;
          end else begin
            row_pos = '0;
            want    = '0;
            if (dirty) begin
              want.changed = 1'b1;
              want.left    = BoxW'(left_min);
              want.top     = BoxW'(top_min);
              want.right   = BoxW'(right_max);
              want.bottom  = BoxW'(bottom_max);
            end
            pending_boxes.push_back(want);
            left_min   = MaxWidth;
            top_min    = MaxHeight;
            right_max  = 0;
            bottom_max = 0;
            dirty      = 1'b0;
          end
        end
      end

      if (box_valid_i && box_ready_i) begin
        got = box_t'(box_data_i[OutW-1:0]);
        if (pending_boxes.size() == 0) begin
          $error("result beat with no frame end pending");
          fail_count++;
        end else begin
          want = pending_boxes.pop_front();
          check_field("box_changed", 32'(want.changed), 32'(got.changed));
          check_field("box_left", 32'(want.left), 32'(got.left));
          check_field("box_top", 32'(want.top), 32'(got.top));
          check_field("box_right", 32'(want.right), 32'(got.right));
          check_field("box_bottom", 32'(want.bottom), 32'(got.bottom));
          check_field("pad", 0, 32'(box_data_i[OutBytesW-1:OutW]));
        end
      end

      fail_count_o <= fail_count;
      pending_o    <= pending_boxes.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
  import drt_pkg::*;

  // run bounds: leave room for the store clear, which covers all 262144 entries
  localparam int unsigned CycleLimit  = 1_500_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 1450;

  // register indexes the block does not decode
  localparam logic [IdxW-1:0] RegSpareLo = IdxW'(2);
  localparam logic [IdxW-1:0] RegSpareHi = IdxW'(3);

  // how a frame's pixels relate to the ones already in the store
  typedef enum int {FillSame, FillRect, FillSparse, FillNoise} fill_e;

  logic                 clk;
  logic                 rst_n;
  logic                 pix_valid;
  logic                 pix_ready;
  logic [PixelW-1:0]    pix_data;
  logic                 box_valid;
  logic                 box_ready;
  logic [OutBytesW-1:0] box_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IdxW-1:0]      cfg_index;
  logic [CfgW-1:0]      cfg_data;
  int                   fail_count;
  int                   pending;

  // stimulus-side copy of what was sent, so frames can repeat or alter it
  logic [PixelW-1:0] canvas [MaxWidth*MaxHeight];
  int unsigned       at_col, at_row;
  int unsigned       cur_w, cur_h;
  int unsigned       items_sent;
  bit                tx_calm;

  dirty_rectangle_tracker dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (pix_valid),
    .s_axis_tready_o (pix_ready),
    .s_axis_tdata_i  (pix_data),
    .m_axis_tvalid_o (box_valid),
    .m_axis_tready_i (box_ready),
    .m_axis_tdata_o  (box_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  dirty_box_checker u_box_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .pix_valid_i  (pix_valid),
    .pix_ready_i  (pix_ready),
    .pix_data_i   (pix_data),
    .box_valid_i  (box_valid),
    .box_ready_i  (box_ready),
    .box_data_i   (box_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** dirty_rectangle_tracker: FAILED **");
    $finish;
  end

  // size as the block uses it: zero acts as one, large values clamp
  function automatic int unsigned eff_size(input logic [CfgW-1:0] v, input int unsigned cap);
    if (v == '0) return 1;
    if (32'(v) > cap) return cap;
    return 32'(v);
  endfunction

  // result side: random stall before each beat, with calm stretches
  initial begin : result_sink
    int unsigned stall;
    bit          rx_calm;
    box_ready <= 1'b0;
    rx_calm = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 5) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        box_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      box_ready <= 1'b1;
      @(posedge clk);
      while (!box_valid) @(posedge clk);
    end
  end

  // one register write; valid stays up when more writes follow
  task automatic cfg_write(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last) cfg_valid <= 1'b0;
    if (idx == RegFrameWidth) cur_w = eff_size(val, MaxWidth);
    else if (idx == RegFrameHeight) cur_h = eff_size(val, MaxHeight);
  endtask

  // hold the pixel stream until every box is out and the pipe is empty
  task automatic settle();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // new frame size, sometimes with a write to an unused index mixed in
  task automatic set_frame(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    settle();
    if ($urandom_range(0, 3) == 0) begin
      cfg_write($urandom_range(0, 1) ? RegSpareLo : RegSpareHi, CfgW'($urandom), 1'b0);
    end
    cfg_write(RegFrameWidth, w, 1'b0);
    cfg_write(RegFrameHeight, h, 1'b1);
  endtask

  // one pixel beat after a random gap; tracks the raster position
  task automatic send_px(input logic [PixelW-1:0] px, output bit frame_end);
    int unsigned gap;
    bit          row_end;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_data  <= px;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    canvas[AddrW'(at_row * MaxWidth + at_col)] = px;
    row_end   = (at_col >= cur_w - 1);
    frame_end = row_end && (at_row >= cur_h - 1);
    if (!row_end) begin
      at_col++;
    end else begin
      at_col = 0;
      at_row = frame_end ? 0 : at_row + 1;
    end
    items_sent++;
  endtask

  // pixels up to the frame end, or at most cap of them when cap is nonzero
  task automatic send_frame(input fill_e fill, input int unsigned cap);
    int unsigned       c0, c1, r0, r1, n;
    bit                fe;
    logic [PixelW-1:0] old, px;
    c0 = $urandom_range(0, cur_w - 1);
    c1 = $urandom_range(c0, cur_w - 1);
    r0 = $urandom_range(0, cur_h - 1);
    r1 = $urandom_range(r0, cur_h - 1);
    n  = 0;
    fe = 1'b0;
    while (!fe && (cap == 0 || n < cap)) begin
      old = canvas[AddrW'(at_row * MaxWidth + at_col)];
      case (fill)
        FillSame: begin
          px = old;
        end
        FillRect: begin
          // changes only inside a random rectangle, about half its pixels
          if (at_col >= c0 && at_col <= c1 && at_row >= r0 && at_row <= r1 &&
              $urandom_range(0, 1) == 1) begin
            px = old ^ PixelW'($urandom_range(1, 65535));
          end else begin
            px = old;
          end
        end
        FillSparse: begin
          px = ($urandom_range(0, 15) == 0) ? old ^ PixelW'($urandom_range(1, 65535)) : old;
        end
        default: begin
          px = PixelW'($urandom);
        end
      endcase
      send_px(px, fe);
      n++;
    end
  endtask

  function automatic fill_e pick_fill();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return FillSame;
    if (r < 55) return FillRect;
    if (r < 85) return FillSparse;
    return FillNoise;
  endfunction

  initial begin : stimulus
    bit          fe;
    int unsigned phase, frames, random_start;
    foreach (canvas[i]) canvas[i] = '0;
    at_col     = 0;
    at_row     = 0;
    cur_w      = eff_size(ResetWidth, MaxWidth);
    cur_h      = eff_size(ResetHeight, MaxHeight);
    items_sent = 0;
    tx_calm    = 1'b0;
    rst_n      = 1'b0;
    pix_valid <= 1'b0;
    pix_data  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= RegFrameWidth;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // single pixel frames: equal to the cleared store, then a change, then a repeat
    set_frame(CfgW'(1), CfgW'(1));
    send_px(16'h0000, fe);
    send_px(16'hFFFF, fe);
    send_px(16'hFFFF, fe);

    // both sizes zero act as one; writes to unused indexes go nowhere
    settle();
    cfg_write(RegSpareLo, '1, 1'b0);
    cfg_write(RegSpareHi, CfgW'($urandom), 1'b0);
    cfg_write(RegFrameWidth, '0, 1'b0);
    cfg_write(RegFrameHeight, '0, 1'b1);
    send_px(16'h8001, fe);

    // small frame with a mix of changed and unchanged pixels
    set_frame(CfgW'(3), CfgW'(2));
    send_px(16'hAAAA, fe);
    send_px(16'h5555, fe);
    send_px(16'h0000, fe);
    send_px(16'h0000, fe);
    send_px(16'h7FFF, fe);
    send_px(16'h0001, fe);

    // width cut below the current column in mid row ends the row and frame
    set_frame(CfgW'(4), CfgW'(3));
    send_frame(FillNoise, 3);
    set_frame(CfgW'(2), CfgW'(1));
    send_frame(FillNoise, 0);

    // height cut below the current row ends the frame at that row's end
    set_frame(CfgW'(2), CfgW'(4));
    send_frame(FillNoise, 6);
    set_frame(CfgW'(2), CfgW'(2));
    send_frame(FillNoise, 0);

    // random phases: mostly small frames, a few full-width or full-height ones
    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RandomItems) begin
      phase++;
      if (phase == 3) begin
        // width past the store clamps to 512 columns
        set_frame('1, CfgW'(1));
        send_frame(pick_fill(), 0);
      end else if (phase == 8) begin
        set_frame(CfgW'(1), CfgW'(MaxHeight));
        send_frame(pick_fill(), 0);
      end else if (phase == 12) begin
        // height past the store, cut short by the next size change
        set_frame(CfgW'(1), '1);
        send_frame(FillSparse, $urandom_range(5, 20));
      end else begin
        set_frame(($urandom_range(0, 3) != 0) ? CfgW'($urandom_range(1, 12))
                                               : CfgW'($urandom_range(0, 24)),
                  CfgW'($urandom_range(0, 6)));
        frames = $urandom_range(1, 4);
        for (int unsigned f = 0; f < frames; f++) begin
          // now and then a frame is broken off and the size changes under it
          if ($urandom_range(0, 11) == 0) begin
            send_frame(pick_fill(), $urandom_range(1, 10));
            break;
          end
          send_frame(pick_fill(), 0);
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("** dirty_rectangle_tracker: PASSED **");
    end else begin
      $display("** dirty_rectangle_tracker: FAILED **");
    end
    $finish;
  end

endmodule
